// File: rtl/core/mbt_pkg.sv
`default_nettype none

package mbt_pkg;

    localparam int NUM_BUTTONS = 2;
    localparam int BTN_UP      = 0;

    localparam int TPM_W   = 16;
    localparam int TEMPO_W = 8;
    localparam int RC_W    = 4;
    localparam int MS_W    = 10;
    localparam int TIME_W  = 6;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_TICKS_PER_MINUTE = 3'd0;
    localparam logic [IDX_W-1:0] REG_TEMPO_MIN        = 3'd1;
    localparam logic [IDX_W-1:0] REG_TEMPO_MAX        = 3'd2;
    localparam logic [IDX_W-1:0] REG_RELEASE_CHECKS   = 3'd3;
    localparam logic [IDX_W-1:0] REG_CHECK_MASK       = 3'd4;
    localparam logic [IDX_W-1:0] REG_TICKS_PER_SECOND = 3'd5;

    localparam logic [TPM_W-1:0]   RST_TICKS_PER_MINUTE = 16'd60000;
    localparam logic [TEMPO_W-1:0] RST_TEMPO_MIN        = 8'd30;
    localparam logic [TEMPO_W-1:0] RST_TEMPO_MAX        = 8'd140;
    localparam logic [RC_W-1:0]    RST_RELEASE_CHECKS   = 4'd10;
    localparam logic [MS_W-1:0]    RST_CHECK_MASK       = 10'h01F;
    localparam logic [MS_W-1:0]    RST_TICKS_PER_SECOND = 10'd1000;
    localparam logic [TPM_W-1:0]   RST_TICKS_PER_BEAT   = 16'd1000;
    localparam logic [TEMPO_W-1:0] RST_TEMPO            = 8'd60;

    localparam logic [TIME_W-1:0]  TIME_LAST   = 6'd59;
    localparam logic [TPM_W-1:0]   PERIOD_SAT  = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/mbt_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module mbt_divider
    import mbt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [TPM_W-1:0]   dividend,
    input  wire logic [TEMPO_W-1:0] divisor,
    output logic                    done,
    output logic [TPM_W-1:0]        quotient
);

    localparam int CNT_W = $clog2(TPM_W + 1);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               done_reg, done_next;
    logic [TEMPO_W-1:0] rem_reg, rem_next;
    logic [TPM_W-1:0]   quo_reg, quo_next;
    logic [TEMPO_W-1:0] div_reg;

    logic [TEMPO_W:0]   rem_shift;
    logic               fits;

    always_comb
    begin
        rem_shift  = {rem_reg, quo_reg[TPM_W-1]};
        fits       = (rem_shift >= {1'b0, div_reg});
        count_next = count_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            count_next = CNT_W'(TPM_W);
            rem_next   = '0;
            quo_next   = dividend;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == CNT_W'(1));
            if (fits)
            begin
                rem_next = TEMPO_W'(rem_shift - {1'b0, div_reg});
            end
            else
            begin
                rem_next = rem_shift[TEMPO_W-1:0];
            end
            quo_next = {quo_reg[TPM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/metronome_beat_timer_core.sv
`default_nettype none

// Metronome beat timer: one word per 1 ms tick, one result word per tick.
// When a button press changes the tempo, the 16-step serial divider recomputes
// ticks per beat before the result word is finished. One tick is in work at a
// time: a new tick is taken only once the last result word is loaded, which waits
// while the output is stalled. Reset (rst_n, asynchronous, active low) restores
// the configuration, state and counter registers but not the output words.
module metronome_beat_timer_core
    import mbt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               wr_en,
    input  wire logic [IDX_W-1:0]   wr_index,
    input  wire logic [TPM_W-1:0]   wr_data,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               up_button_n,
    input  wire logic               down_button_n,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    beat,
    output logic [TEMPO_W-1:0]      tempo,
    output logic [TIME_W-1:0]       seconds,
    output logic [TIME_W-1:0]       minutes,
    output logic                    refresh
);

    // Configuration registers.
    logic [TPM_W-1:0]   tpm_reg;
    logic [TEMPO_W-1:0] tempo_min_reg;
    logic [TEMPO_W-1:0] tempo_max_reg;
    logic [RC_W-1:0]    release_checks_reg;
    logic [MS_W-1:0]    check_mask_reg;
    logic [MS_W-1:0]    tps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpm_reg            <= RST_TICKS_PER_MINUTE;
            tempo_min_reg      <= RST_TEMPO_MIN;
            tempo_max_reg      <= RST_TEMPO_MAX;
            release_checks_reg <= RST_RELEASE_CHECKS;
            check_mask_reg     <= RST_CHECK_MASK;
            tps_reg            <= RST_TICKS_PER_SECOND;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TICKS_PER_MINUTE: tpm_reg            <= wr_data;
                REG_TEMPO_MIN:        tempo_min_reg      <= wr_data[TEMPO_W-1:0];
                REG_TEMPO_MAX:        tempo_max_reg      <= wr_data[TEMPO_W-1:0];
                REG_RELEASE_CHECKS:   release_checks_reg <= wr_data[RC_W-1:0];
                REG_CHECK_MASK:       check_mask_reg     <= wr_data[MS_W-1:0];
                REG_TICKS_PER_SECOND: tps_reg            <= wr_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // Block state.
    state_t                  state_reg, state_next;
    logic [MS_W-1:0]         ms_reg, ms_next;
    logic [TPM_W-1:0]        bt_reg, bt_next;
    logic [TPM_W-1:0]        tpb_reg, tpb_next;
    logic [TEMPO_W-1:0]      tempo_reg, tempo_next;
    logic [TIME_W-1:0]       sec_reg, sec_next;
    logic [TIME_W-1:0]       min_reg, min_next;
    logic [NUM_BUTTONS-1:0]  flag_reg, flag_next;
    logic [RC_W-1:0]         rc_reg [NUM_BUTTONS];
    logic [RC_W-1:0]         rc_next [NUM_BUTTONS];
    logic                    press_reg, press_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    beat_reg, beat_next;
    logic [TEMPO_W-1:0]      tempo_out_reg;
    logic [TIME_W-1:0]       sec_out_reg;
    logic [TIME_W-1:0]       min_out_reg;
    logic                    refresh_reg, refresh_next;
    logic                    load_out;

    logic                    div_start;
    logic                    div_done;
    logic [TPM_W-1:0]        div_quotient;

    mbt_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tpm_reg),
        .divisor  (tempo_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin : next_state
        logic [NUM_BUTTONS-1:0] level;
        logic                   check;
        logic [RC_W-1:0]        rc_inc;

        level = {down_button_n, up_button_n};
        check = 1'b0;
        rc_inc = '0;

        state_next     = state_reg;
        ms_next        = ms_reg;
        bt_next        = bt_reg;
        tpb_next       = tpb_reg;
        tempo_next     = tempo_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        flag_next      = flag_reg;
        press_next     = press_reg;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            rc_next[i] = rc_reg[i];
        end
        div_start      = 1'b0;
        load_out       = 1'b0;
        beat_next      = 1'b0;
        refresh_next   = press_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ms_next    = ms_reg + 1'b1;
                    bt_next    = bt_reg + 1'b1;
                    press_next = 1'b0;
                    check      = ((ms_next & check_mask_reg) == '0);
                    if (check)
                    begin
                        // Buttons are checked in order, so a press of both
                        // steps the tempo twice.
                        for (int i = 0; i < NUM_BUTTONS; i++)
                        begin
                            if (!level[i] && !flag_next[i])
                            begin
                                flag_next[i] = 1'b1;
                                press_next   = 1'b1;
                                if (i == BTN_UP)
                                begin
                                    tempo_next = (tempo_next >= tempo_max_reg) ?
                                                 tempo_min_reg : tempo_next + 1'b1;
                                end
                                else
                                begin
                                    tempo_next = (tempo_next <= tempo_min_reg) ?
                                                 tempo_max_reg : tempo_next - 1'b1;
                                end
                            end
                            else
                            begin
                                rc_inc = rc_reg[i] + 1'b1;
                                if (rc_inc == release_checks_reg)
                                begin
                                    rc_next[i]   = '0;
                                    flag_next[i] = 1'b0;
                                end
                                else
                                begin
                                    rc_next[i] = rc_inc;
                                end
                            end
                        end
                    end
                    if (press_next)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    tpb_next   = (tempo_reg == '0) ? PERIOD_SAT : div_quotient;
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                // Hold the finished word until the output register is free.
                if (!(out_valid_reg && out_stall))
                begin
                    load_out = 1'b1;
                    if (bt_reg == tpb_reg)
                    begin
                        beat_next = 1'b1;
                        bt_next   = '0;
                    end
                    else if (bt_reg > tpb_reg)
                    begin
                        bt_next = '0;
                    end
                    if (ms_reg == tps_reg)
                    begin
                        refresh_next = 1'b1;
                        ms_next      = '0;
                        if (sec_reg == TIME_LAST)
                        begin
                            sec_next = '0;
                            min_next = (min_reg == TIME_LAST) ? '0 : min_reg + 1'b1;
                        end
                        else
                        begin
                            sec_next = sec_reg + 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ms_reg        <= '0;
            bt_reg        <= '0;
            tpb_reg       <= RST_TICKS_PER_BEAT;
            tempo_reg     <= RST_TEMPO;
            sec_reg       <= '0;
            min_reg       <= '0;
            flag_reg      <= '0;
            press_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                rc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ms_reg        <= ms_next;
            bt_reg        <= bt_next;
            tpb_reg       <= tpb_next;
            tempo_reg     <= tempo_next;
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            flag_reg      <= flag_next;
            press_reg     <= press_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                rc_reg[i] <= rc_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            beat_reg      <= beat_next;
            tempo_out_reg <= tempo_reg;
            sec_out_reg   <= sec_next;
            min_out_reg   <= min_next;
            refresh_reg   <= refresh_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign beat      = beat_reg;
    assign tempo     = tempo_out_reg;
    assign seconds   = sec_out_reg;
    assign minutes   = min_out_reg;
    assign refresh   = refresh_reg;

endmodule

`default_nettype wire
